>>> src/svn_pkg.sv
// ----------------------------------------------------------------------------
// svn_pkg: shared types and codes of the sector variance normalizer
// Item and result structs, command and register codes, sequencer states.
// ----------------------------------------------------------------------------
package svn_pkg;

  localparam logic [1:0] FUNC_ACCUM = 2'd0;
  localparam logic [1:0] FUNC_NORM  = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  localparam logic [1:0] CFG_MEAN_TARGET = 2'd0;
  localparam logic [1:0] CFG_VAR_TARGET  = 2'd1;
  localparam logic [1:0] CFG_OUT_MODE    = 2'd2;
  localparam logic [1:0] CFG_MIX_SELECT  = 2'd3;

  localparam logic       MODE_NORM = 1'b0;
  localparam logic [1:0] MIX_FORCE = 2'd0;
  localparam logic [1:0] MIX_PLAIN = 2'd1;

  localparam logic KIND_PIXEL    = 1'b0;
  localparam logic KIND_VARIANCE = 1'b1;

  localparam logic [7:0]  MT_RESET  = 8'd50;
  localparam logic [15:0] VT_RESET  = 16'd50;
  localparam logic [25:0] FIXED_50  = 26'd12800;
  localparam logic [31:0] VAR_ONE   = 32'd65536;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [15:0] pixel;
    logic [6:0]         sector;
  } svn_in_t;

  typedef struct packed {
    logic               reply_kind;
    logic signed [15:0] norm_value;
    logic [31:0]        variance_value;
  } svn_out_t;

  typedef struct packed {
    logic [7:0]  mean_target;
    logic [15:0] variance_target;
    logic        output_mode;
    logic [1:0]  mix_select;
  } svn_cfg_t;

  // classified item as it waits between front and back
  typedef struct packed {
    logic [1:0]         func;
    logic signed [15:0] pixel;
    logic [7:0]         idx;
    logic               in_range;
    logic               last2;
  } svn_job_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LOAD, ST_MUL1, ST_MUL2, ST_MUL3, ST_NUM, ST_DIVM, ST_DIVV,
    ST_DIFF, ST_SQ1, ST_SQ2, ST_DIVT, ST_SQRT, ST_FINISH
  } svn_state_t;

endpackage

>>> src/sector_variance_normalizer_core.sv
// ----------------------------------------------------------------------------
// sector_variance_normalizer_core: per-sector pixel statistics and normalizer
// Command intake and job queue in front, statistics sequencer behind it.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive item and raise start; the item is taken at an edge
//   where start is high and busy is low. func 0 adds a pixel to its sector,
//   func 1 normalizes a pixel, func 2 returns a sector's variance and empties
//   the sector. Accumulates to an outside sector and func 3 do no work.
//   Result channel: result_strobe is high for one cycle with result; the
//   receiver cannot stall, so every result is a transfer in that cycle.
//   Configuration: cfg_valid/cfg_index/cfg_data, always ready; write only
//   while the block is idle.
// Timing:
//   A two-entry queue holds jobs; busy is high while it is full. The
//   sequencer takes one job at a time: an accumulate loads and returns to
//   idle, an empty or outside sector goes from load to finish, a variance
//   runs the products and the bit-serial divider twice; a full normalize adds
//   the difference, square, a third division and the 24-step root.
// Reset: synchronous, clears the queue, all sector totals (by valid bits)
//   and loads the register defaults.
// ----------------------------------------------------------------------------
module sector_variance_normalizer_core #(
  parameter int SECTORS    = 74,
  parameter int MAX_PIXELS = 32768
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  svn_pkg::svn_in_t  item,
  output logic              result_strobe,
  output svn_pkg::svn_out_t result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data
);

  svn_pkg::svn_cfg_t cfg;
  logic              q_valid;
  logic              q_pop;
  svn_pkg::svn_job_t q_head;

  assign cfg_ready = 1'b1;

  // register file: hold values between transfers on the configuration port
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mean_target     <= svn_pkg::MT_RESET;
      cfg.variance_target <= svn_pkg::VT_RESET;
      cfg.output_mode     <= svn_pkg::MODE_NORM;
      cfg.mix_select      <= svn_pkg::MIX_FORCE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        svn_pkg::CFG_MEAN_TARGET: cfg.mean_target     <= cfg_data[7:0];
        svn_pkg::CFG_VAR_TARGET:  cfg.variance_target <= cfg_data;
        svn_pkg::CFG_OUT_MODE:    cfg.output_mode     <= cfg_data[0];
        svn_pkg::CFG_MIX_SELECT:  cfg.mix_select      <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // front: classify and queue commands
  svn_front #(.SECTORS(SECTORS)) u_front (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .q_valid(q_valid), .q_head(q_head), .q_pop(q_pop)
  );

  // back: sector store and arithmetic sequencer
  svn_back #(.SECTORS(SECTORS), .MAX_PIXELS(MAX_PIXELS)) u_back (
    .clk(clk), .rst(rst), .cfg(cfg), .q_valid(q_valid), .q_head(q_head),
    .q_pop(q_pop), .result_strobe(result_strobe), .result(result)
  );

endmodule

>>> src/svn_front.sv
// ----------------------------------------------------------------------------
// svn_front: command intake and job queue
// Classifies each item, drops those that do no work, queues the rest.
// ----------------------------------------------------------------------------
module svn_front #(
  parameter int SECTORS = 74
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  svn_pkg::svn_in_t item,
  output logic             q_valid,
  output svn_pkg::svn_job_t q_head,
  input  logic             q_pop
);

  svn_pkg::svn_job_t slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  svn_pkg::svn_job_t job_in;
  logic       keep;
  logic       push;
  logic [7:0] sec8;

  always_comb begin
    sec8            = {1'b0, item.sector};
    job_in.func     = item.func;
    job_in.pixel    = item.pixel;
    job_in.idx      = sec8 - 8'd1;
    job_in.in_range = (sec8 != 8'd0) && (sec8 <= 8'(SECTORS));
    job_in.last2    = (sec8 == 8'(SECTORS - 1)) || (sec8 == 8'(SECTORS));
    keep = (item.func == svn_pkg::FUNC_NORM) || (item.func == svn_pkg::FUNC_CLEAR) ||
           ((item.func == svn_pkg::FUNC_ACCUM) && job_in.in_range);
  end

  assign busy    = (count == 2'd2);
  assign push    = start && !busy && keep;
  assign q_valid = (count != 2'd0);
  assign q_head  = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= job_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (q_pop) rd_ptr <= !rd_ptr;
      count <= count + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule

>>> src/svn_div.sv
// ----------------------------------------------------------------------------
// svn_div: bit-serial unsigned divider
// 64-bit dividend by 32-bit divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module svn_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        busy,
  output logic        done,
  output logic [63:0] quotient,
  output logic [31:0] remainder
);

  logic [63:0] dvd;
  logic [31:0] dsr;
  logic [6:0]  cnt;
  logic [32:0] rsh;
  logic        fit;

  assign rsh = {remainder, dvd[63]};
  assign fit = rsh >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (start) begin
      dvd       <= dividend;
      dsr       <= divisor;
      remainder <= 32'd0;
    end else if (busy) begin
      dvd       <= {dvd[62:0], 1'b0};
      quotient  <= {quotient[62:0], fit};
      remainder <= fit ? 32'(rsh - {1'b0, dsr}) : rsh[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 7'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 7'd64;
      end else if (busy) begin
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> src/svn_sqrt.sv
// ----------------------------------------------------------------------------
// svn_sqrt: digit-by-digit integer square root
// 48-bit operand, one root bit per cycle, 24-bit root.
// ----------------------------------------------------------------------------
module svn_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [47:0] operand,
  output logic        done,
  output logic [23:0] root
);

  logic [47:0] op;
  logic [25:0] rem;
  logic [4:0]  cnt;
  logic        run;
  logic [27:0] rsh;
  logic [27:0] trial;
  logic        fit;

  assign rsh   = {rem, op[47:46]};
  assign trial = {2'b00, root, 2'b01};
  assign fit   = rsh >= trial;

  always_ff @(posedge clk) begin
    if (start) begin
      op   <= operand;
      rem  <= 26'd0;
      root <= 24'd0;
    end else if (run) begin
      op   <= {op[45:0], 2'b00};
      rem  <= fit ? 26'(rsh - trial) : rsh[25:0];
      root <= {root[22:0], fit};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= 5'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= 5'd24;
      end else if (run) begin
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> src/svn_back.sv
// ----------------------------------------------------------------------------
// svn_back: sector store and statistics sequencer
// Updates and empties sector sums, forms mean and variance, normalizes the pixel.
// ----------------------------------------------------------------------------
module svn_back #(
  parameter int SECTORS    = 74,
  parameter int MAX_PIXELS = 32768
) (
  input  logic              clk,
  input  logic              rst,
  input  svn_pkg::svn_cfg_t cfg,
  input  logic              q_valid,
  input  svn_pkg::svn_job_t q_head,
  output logic              q_pop,
  output logic              result_strobe,
  output svn_pkg::svn_out_t result
);

  localparam int IW  = $clog2(SECTORS);
  localparam int CAP = (MAX_PIXELS < 65535) ? MAX_PIXELS : 65535;

  typedef struct packed {
    logic signed [31:0] sum;
    logic [45:0]        sq;
    logic [15:0]        cnt;
  } svn_rec_t;

  svn_rec_t          mem [SECTORS];
  logic [SECTORS-1:0] valid;
  svn_rec_t          rdata;
  logic              vbit;

  svn_pkg::svn_state_t st, st_next;
  svn_pkg::svn_job_t   job;

  logic [IW-1:0]      rd_idx;
  logic [IW-1:0]      idx;
  logic [31:0]        xsq;
  svn_rec_t           ld;
  logic signed [31:0] e_sum;
  logic [45:0]        e_sq;
  logic [15:0]        e_cnt;
  logic [31:0]        magn;
  logic [63:0]        ss;
  logic [31:0]        nn;
  logic [38:0]        nqlo;
  logic [38:0]        nqhi;
  logic [63:0]        nq;
  logic [63:0]        num;
  logic [17:0]        mean;
  logic [17:0]        mq;
  logic [17:0]        mean_calc;
  logic [17:0]        d;
  logic [31:0]        var_q;
  logic [31:0]        var_calc;
  logic               go_norm;
  logic [15:0]        ad;
  logic               dneg;
  logic [31:0]        adsq;
  logic [23:0]        delta;
  logic               mem_we;
  svn_rec_t           wr_rec;

  logic        div_start;
  logic [63:0] div_a;
  logic [31:0] div_b;
  logic        div_busy;
  logic        div_done;
  logic [63:0] div_quo;
  logic [31:0] div_rem;
  logic        sqrt_start;
  logic [47:0] sqrt_op;
  logic        sqrt_done;
  logic [23:0] sqrt_root;

  logic [25:0] base;
  logic [25:0] res;
  logic [15:0] res_sat;

  svn_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_a), .divisor(div_b),
    .busy(div_busy), .done(div_done), .quotient(div_quo), .remainder(div_rem)
  );

  svn_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sqrt_start), .operand(sqrt_op),
    .done(sqrt_done), .root(sqrt_root)
  );

  assign q_pop  = (st == svn_pkg::ST_IDLE) && q_valid;
  assign rd_idx = q_head.in_range ? q_head.idx[IW-1:0] : '0;
  assign idx    = job.idx[IW-1:0];

  // sector store: registered read, entries not yet valid read as zero
  always_ff @(posedge clk) begin
    if (mem_we) mem[idx] <= wr_rec;
    if (q_pop) rdata <= mem[rd_idx];
  end

  always_comb begin
    ld = (vbit && job.in_range) ? rdata : '0;
    wr_rec.sum = ld.sum + {{16{job.pixel[15]}}, job.pixel};
    wr_rec.sq  = ld.sq + {14'd0, xsq};
    wr_rec.cnt = ld.cnt + 16'd1;
    mem_we = (st == svn_pkg::ST_LOAD) && (job.func == svn_pkg::FUNC_ACCUM) &&
             job.in_range && (ld.cnt < 16'(CAP));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      vbit  <= 1'b0;
    end else begin
      if (q_pop) vbit <= valid[rd_idx];
      if (mem_we) valid[idx] <= 1'b1;
      else if ((st == svn_pkg::ST_LOAD) && (job.func == svn_pkg::FUNC_CLEAR) && job.in_range)
        valid[idx] <= 1'b0;
    end
  end

  always_comb begin
    magn      = e_sum[31] ? 32'(32'd0 - e_sum) : e_sum;
    nq        = {2'b00, nqhi, 23'd0} + {25'd0, nqlo};
    mq        = {1'b0, div_quo[16:0]};
    mean_calc = e_sum[31] ? (18'd0 - mq - {17'd0, (div_rem != 32'd0)}) : mq;
    var_calc  = (div_quo[63:32] != 32'd0) ? 32'hFFFF_FFFF : div_quo[31:0];
    go_norm   = (job.func == svn_pkg::FUNC_NORM) && (cfg.output_mode == svn_pkg::MODE_NORM)
                && (var_calc > svn_pkg::VAR_ONE)
                && !(job.last2 && (cfg.mix_select == svn_pkg::MIX_FORCE));
    d = {{2{job.pixel[15]}}, job.pixel} - mean;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= svn_pkg::ST_IDLE;
    end else begin
      st <= st_next;
    end
  end

  always_comb begin
    st_next = st;
    unique case (st)
      svn_pkg::ST_IDLE:   if (q_valid) st_next = svn_pkg::ST_LOAD;
      svn_pkg::ST_LOAD: begin
        if (job.func == svn_pkg::FUNC_ACCUM) st_next = svn_pkg::ST_IDLE;
        else if (!job.in_range || (ld.cnt == 16'd0)) st_next = svn_pkg::ST_FINISH;
        else st_next = svn_pkg::ST_MUL1;
      end
      svn_pkg::ST_MUL1:   st_next = svn_pkg::ST_MUL2;
      svn_pkg::ST_MUL2:   st_next = svn_pkg::ST_MUL3;
      svn_pkg::ST_MUL3:   st_next = svn_pkg::ST_NUM;
      svn_pkg::ST_NUM:    st_next = svn_pkg::ST_DIVM;
      svn_pkg::ST_DIVM:   if (div_done) st_next = svn_pkg::ST_DIVV;
      svn_pkg::ST_DIVV: begin
        if (div_done) st_next = go_norm ? svn_pkg::ST_DIFF : svn_pkg::ST_FINISH;
      end
      svn_pkg::ST_DIFF:   st_next = svn_pkg::ST_SQ1;
      svn_pkg::ST_SQ1:    st_next = svn_pkg::ST_SQ2;
      svn_pkg::ST_SQ2:    st_next = svn_pkg::ST_DIVT;
      svn_pkg::ST_DIVT:   if (div_done) st_next = svn_pkg::ST_SQRT;
      svn_pkg::ST_SQRT:   if (sqrt_done) st_next = svn_pkg::ST_FINISH;
      svn_pkg::ST_FINISH: st_next = svn_pkg::ST_IDLE;
      default:            st_next = svn_pkg::ST_IDLE;
    endcase
  end

  // datapath registers, one step per state
  always_ff @(posedge clk) begin
    case (st)
      svn_pkg::ST_IDLE: begin
        job <= q_head;
        xsq <= 32'(q_head.pixel * q_head.pixel);
      end
      svn_pkg::ST_LOAD: begin
        e_sum <= ld.sum;
        e_sq  <= ld.sq;
        e_cnt <= ld.cnt;
        mean  <= 18'd0;
        var_q <= 32'd0;
      end
      svn_pkg::ST_MUL1: begin
        ss <= magn * magn;
        nn <= e_cnt * e_cnt;
      end
      svn_pkg::ST_MUL2: nqlo <= e_cnt * e_sq[22:0];
      svn_pkg::ST_MUL3: nqhi <= e_cnt * e_sq[45:23];
      svn_pkg::ST_NUM: begin
        num   <= (nq > ss) ? (nq - ss) : 64'd0;
        div_a <= {32'd0, magn};
        div_b <= {16'd0, e_cnt};
      end
      svn_pkg::ST_DIVM: begin
        if (div_done) begin
          mean  <= mean_calc;
          div_a <= num;
          div_b <= nn;
        end
      end
      svn_pkg::ST_DIVV: if (div_done) var_q <= var_calc;
      svn_pkg::ST_DIFF: begin
        dneg <= d[17];
        ad   <= d[17] ? 16'(18'd0 - d) : d[15:0];
      end
      svn_pkg::ST_SQ1:  adsq <= ad * ad;
      svn_pkg::ST_SQ2: begin
        // dividend is variance_target * d^2 in Q16, ready as the start pulse rises
        div_a <= {48'(cfg.variance_target * adsq), 16'd0};
        div_b <= var_q;
      end
      svn_pkg::ST_DIVT: if (div_done) sqrt_op <= div_quo[47:0];
      svn_pkg::ST_SQRT: if (sqrt_done) delta <= sqrt_root;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_start  <= 1'b0;
      sqrt_start <= 1'b0;
    end else begin
      div_start  <= (st == svn_pkg::ST_NUM) || ((st == svn_pkg::ST_DIVM) && div_done) ||
                    (st == svn_pkg::ST_SQ2);
      sqrt_start <= (st == svn_pkg::ST_DIVT) && div_done;
    end
  end

  // pixel result: target mean, forced 50.0 or target mean +/- root, then saturate
  always_comb begin
    base = {10'd0, cfg.mean_target, 8'd0};
    if (job.in_range && (var_q > svn_pkg::VAR_ONE)) begin
      if (job.last2 && (cfg.mix_select == svn_pkg::MIX_FORCE)) res = svn_pkg::FIXED_50;
      else res = dneg ? (base - {2'b00, delta}) : (base + {2'b00, delta});
    end else begin
      res = base;
    end
    if (!res[25] && (res > 26'd32767)) res_sat = 16'h7FFF;
    else if (res[25] && (res < 26'h3FF_8000)) res_sat = 16'h8000;
    else res_sat = res[15:0];
  end

  always_ff @(posedge clk) begin
    if (st == svn_pkg::ST_FINISH) begin
      if (job.func == svn_pkg::FUNC_CLEAR) begin
        result.reply_kind     <= svn_pkg::KIND_VARIANCE;
        result.norm_value     <= 16'sd0;
        result.variance_value <= var_q;
      end else if (cfg.output_mode != svn_pkg::MODE_NORM) begin
        result.reply_kind     <= svn_pkg::KIND_PIXEL;
        result.norm_value     <= 16'sd0;
        result.variance_value <= ((cfg.mix_select == svn_pkg::MIX_FORCE) ||
                                  (cfg.mix_select == svn_pkg::MIX_PLAIN)) ? var_q : 32'd0;
      end else begin
        result.reply_kind     <= svn_pkg::KIND_PIXEL;
        result.norm_value     <= $signed(res_sat);
        result.variance_value <= 32'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) result_strobe <= 1'b0;
    else result_strobe <= (st == svn_pkg::ST_FINISH);
  end

`ifndef SYNTHESIS
  a_finish_idle: assert property (@(posedge clk) disable iff (rst)
    st == svn_pkg::ST_FINISH |=> st == svn_pkg::ST_IDLE)
    else $error("sequencer did not return to idle after a result");
  a_div_free: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider started while still running");
  a_reply_kind: assert property (@(posedge clk) disable iff (rst)
    result_strobe && (result.reply_kind == svn_pkg::KIND_VARIANCE) |->
    job.func == svn_pkg::FUNC_CLEAR)
    else $error("read reply without a read-and-clear item");
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> st == svn_pkg::ST_LOAD)
    else $error("popped job not loaded");
`endif

endmodule

>>> tb/sv/svn_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// svn_result_checker: prediction and comparison for the sector normalizer
// Watches command, configuration and result transfers, keeps its own sector
// totals and register copies, and compares every result in order.
// ----------------------------------------------------------------------------
module svn_result_checker #(
  parameter int SECTORS    = 74,
  parameter int MAX_PIXELS = 32768
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  svn_pkg::svn_in_t  item,
  input  logic              result_strobe,
  input  svn_pkg::svn_out_t result,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  output int                errors,
  output int                pending
);

  localparam int COUNT_CAP = (MAX_PIXELS < 65535) ? MAX_PIXELS : 65535;

  longint            tot_sum [SECTORS];
  logic [63:0]       tot_sq  [SECTORS];
  int                tot_cnt [SECTORS];
  logic [7:0]        mean_tgt;
  logic [15:0]       var_tgt;
  logic              out_mode;
  logic [1:0]        mix_sel;
  svn_pkg::svn_out_t awaited[$];

  function automatic logic [63:0] int_root(logic [63:0] v);
    logic [63:0] root;
    logic [63:0] b;
    root = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= root + b) begin
        v = v - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return root;
  endfunction

  // sector mean (Q8.8, floored) and variance (Q16.16, clamped)
  task automatic sector_moments(int k, output longint mean, output logic [63:0] var_q);
    longint      n;
    longint      s;
    logic [63:0] mag;
    logic [63:0] nq;
    logic [63:0] s2;
    logic [63:0] v;
    n = tot_cnt[k];
    s = tot_sum[k];
    mean = 0;
    var_q = 0;
    if (n != 0) begin
      mean = s / n;
      if ((s % n) != 0 && s < 0) mean = mean - 1;
      mag = (s < 0) ? 64'(-s) : 64'(s);
      nq = 64'(n) * tot_sq[k];
      s2 = mag * mag;
      v = (nq > s2) ? (nq - s2) / (64'(n) * 64'(n)) : 64'd0;
      var_q = (v > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : v;
    end
  endtask

  // advance the sector totals by one command and work out its result
  task automatic normalize_step(svn_pkg::svn_in_t it, output bit has_res,
                                output svn_pkg::svn_out_t r);
    longint      x;
    int          sec;
    bit          in_range;
    int          k;
    longint      mean;
    logic [63:0] var_q;
    longint      res;
    longint      d;
    logic [63:0] ad;
    logic [63:0] a;
    logic [63:0] t;
    x = longint'(it.pixel);
    sec = it.sector;
    in_range = (sec >= 1 && sec <= SECTORS);
    k = in_range ? sec - 1 : 0;
    mean = 0;
    var_q = 0;
    has_res = 0;
    r = '0;
    if (it.func == svn_pkg::FUNC_ACCUM) begin
      if (in_range && tot_cnt[k] < COUNT_CAP) begin
        tot_sum[k] += x;
        tot_sq[k] += 64'(x * x);
        tot_cnt[k] += 1;
      end
    end else if (it.func == svn_pkg::FUNC_CLEAR) begin
      if (in_range) begin
        sector_moments(k, mean, var_q);
        tot_sum[k] = 0;
        tot_sq[k] = 0;
        tot_cnt[k] = 0;
      end
      has_res = 1;
      r.reply_kind = svn_pkg::KIND_VARIANCE;
      r.variance_value = var_q[31:0];
    end else if (it.func == svn_pkg::FUNC_NORM) begin
      if (in_range) sector_moments(k, mean, var_q);
      has_res = 1;
      r.reply_kind = svn_pkg::KIND_PIXEL;
      if (out_mode != svn_pkg::MODE_NORM) begin
        r.variance_value = (mix_sel == svn_pkg::MIX_FORCE || mix_sel == svn_pkg::MIX_PLAIN) ?
                           var_q[31:0] : '0;
      end else begin
        res = longint'(mean_tgt) * 256;
        if (in_range && var_q > 64'd65536) begin
          if ((sec == SECTORS - 1 || sec == SECTORS) && mix_sel == svn_pkg::MIX_FORCE) begin
            res = 12800;
          end else begin
            d = x - mean;
            ad = (d < 0) ? 64'(-d) : 64'(d);
            a = 64'(var_tgt) * ad * ad;
            t = ((a / var_q) << 16) + (((a % var_q) << 16) / var_q);
            res = (d < 0) ? res - longint'(int_root(t)) : res + longint'(int_root(t));
          end
        end
        if (res > 32767) res = 32767;
        if (res < -32768) res = -32768;
        r.norm_value = res[15:0];
      end
    end
  endtask

  always @(posedge clk) begin
    bit                has_res;
    svn_pkg::svn_out_t want;
    if (rst) begin
      for (int i = 0; i < SECTORS; i++) begin
        tot_sum[i] = 0;
        tot_sq[i] = 0;
        tot_cnt[i] = 0;
      end
      mean_tgt = svn_pkg::MT_RESET;
      var_tgt = svn_pkg::VT_RESET;
      out_mode = svn_pkg::MODE_NORM;
      mix_sel = svn_pkg::MIX_FORCE;
      awaited.delete();
      errors <= 0;
    end else begin
      // compare first: a result in this cycle always belongs to an older command
      if (result_strobe) begin
        if (awaited.size() == 0) begin
          if (errors < 10) $display("unexpected result %p", result);
          errors <= errors + 1;
        end else begin
          want = awaited.pop_front();
          if (want.reply_kind !== result.reply_kind || want.norm_value !== result.norm_value ||
              want.variance_value !== result.variance_value) begin
            if (errors < 10)
              $display("mismatch: expected kind %0d norm %0d var %0d, got kind %0d norm %0d var %0d",
                       want.reply_kind, want.norm_value, want.variance_value,
                       result.reply_kind, result.norm_value, result.variance_value);
            errors <= errors + 1;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          svn_pkg::CFG_MEAN_TARGET: mean_tgt = cfg_data[7:0];
          svn_pkg::CFG_VAR_TARGET:  var_tgt = cfg_data;
          svn_pkg::CFG_OUT_MODE:    out_mode = cfg_data[0];
          svn_pkg::CFG_MIX_SELECT:  mix_sel = cfg_data[1:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        normalize_step(item, has_res, want);
        if (has_res) awaited.push_back(want);
      end
    end
    pending <= awaited.size();
  end

endmodule

>>> tb/sv/tb_sector_variance_normalizer_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sector_variance_normalizer_core: stimulus for the sector normalizer
// Directed corner commands, then phases of random register settings with
// accumulate, normalize and read-and-clear traffic; the checker judges.
// ----------------------------------------------------------------------------
module tb_sector_variance_normalizer_core;

  localparam int         SECTORS   = 74;
  localparam int         DRAIN_CYC = 400;   // longer than the longest job
  localparam int         STALL_MAX = 5000;  // watchdog: cycles with no transfer
  localparam logic [1:0] FUNC_NONE = 2'd3;  // unused command code

  logic              clk = 0;
  logic              rst = 1;
  logic              start = 0;
  logic              busy;
  svn_pkg::svn_in_t  item = '0;
  logic              result_strobe;
  svn_pkg::svn_out_t result;
  logic              cfg_valid = 0;
  logic              cfg_ready;
  logic [1:0]        cfg_index = svn_pkg::CFG_MEAN_TARGET;
  logic [15:0]       cfg_data = '0;
  int                errors;
  int                pending;
  int                quiet_cycles = 0;
  bit                calm = 0;  // no idling in the closing stretch

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  sector_variance_normalizer_core #(.SECTORS(SECTORS), .MAX_PIXELS(32768)) DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .result_strobe(result_strobe), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  svn_result_checker #(.SECTORS(SECTORS), .MAX_PIXELS(32768)) u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .result_strobe(result_strobe), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  // watchdog: any transfer on any channel resets the count
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_strobe || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_MAX) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // offer a command until an edge takes it; start stays high but for random gaps
  task automatic issue(logic [1:0] f, logic [15:0] px, logic [6:0] sec);
    svn_pkg::svn_in_t it;
    it.func = f;
    it.pixel = px;
    it.sector = sec;
    start <= 1;
    item <= it;
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
    if (!calm && $urandom_range(0, 4) == 0) begin
      start <= 0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  // drop start and wait for every result, then let trailing accumulates finish
  task automatic drain();
    start <= 0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  // one register transfer, then the configuration port idles
  task automatic reg_write(logic [1:0] idx, logic [15:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  function automatic logic [15:0] pick_pixel();
    case ($urandom_range(0, 3))
      0:       return 16'($urandom_range(0, 65535));
      1:       return 16'h8000 ^ 16'($urandom_range(0, 3));
      default: return 16'($urandom_range(0, 8191)) + 16'($urandom_range(0, 65535) & 16'hF000);
    endcase
  endfunction

  initial begin
    int       sent;
    int       pick;
    int       group[4];
    logic [6:0] sec;
    rst = 1;
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: field extremes, forced last sectors, outside pixels, empty sectors
    issue(svn_pkg::FUNC_ACCUM, 16'h7FFF, 7'd1);
    issue(svn_pkg::FUNC_ACCUM, 16'h8000, 7'd1);
    issue(svn_pkg::FUNC_ACCUM, 16'h0000, 7'd1);
    issue(svn_pkg::FUNC_ACCUM, 16'h0100, 7'd1);
    issue(svn_pkg::FUNC_ACCUM, 16'h7FFF, 7'd74);
    issue(svn_pkg::FUNC_ACCUM, 16'h8000, 7'd74);
    issue(svn_pkg::FUNC_ACCUM, 16'h1234, 7'd73);
    issue(svn_pkg::FUNC_ACCUM, 16'hF000, 7'd73);
    issue(svn_pkg::FUNC_ACCUM, 16'h5555, 7'd0);
    issue(svn_pkg::FUNC_ACCUM, 16'hAAAA, 7'd127);
    issue(svn_pkg::FUNC_ACCUM, 16'h0100, 7'd2);
    issue(svn_pkg::FUNC_ACCUM, 16'h0100, 7'd2);
    issue(FUNC_NONE, 16'hFFFF, 7'd1);
    issue(svn_pkg::FUNC_NORM, 16'h7FFF, 7'd1);
    issue(svn_pkg::FUNC_NORM, 16'h8000, 7'd1);
    issue(svn_pkg::FUNC_NORM, 16'h0000, 7'd74);
    issue(svn_pkg::FUNC_NORM, 16'h0000, 7'd73);
    issue(svn_pkg::FUNC_NORM, 16'h0300, 7'd2);
    issue(svn_pkg::FUNC_NORM, 16'h0100, 7'd0);
    issue(svn_pkg::FUNC_NORM, 16'h0100, 7'd100);
    issue(svn_pkg::FUNC_NORM, 16'h0100, 7'd5);
    issue(svn_pkg::FUNC_CLEAR, 16'h0000, 7'd1);
    issue(svn_pkg::FUNC_CLEAR, 16'h0000, 7'd0);
    issue(svn_pkg::FUNC_CLEAR, 16'h0000, 7'd127);
    issue(svn_pkg::FUNC_NORM, 16'h0100, 7'd1);

    // random phases: fresh register settings, extremes in the first ones
    sent = 0;
    for (int ph = 0; ph < 10; ph++) begin
      drain();
      case (ph)
        0: begin
          reg_write(svn_pkg::CFG_MEAN_TARGET, 16'd0);
          reg_write(svn_pkg::CFG_VAR_TARGET, 16'd0);
          reg_write(svn_pkg::CFG_OUT_MODE, 16'd0);
          reg_write(svn_pkg::CFG_MIX_SELECT, 16'd0);
        end
        1: begin
          reg_write(svn_pkg::CFG_MEAN_TARGET, 16'd255);
          reg_write(svn_pkg::CFG_VAR_TARGET, 16'hFFFF);
          reg_write(svn_pkg::CFG_MIX_SELECT, 16'd1);
        end
        2: begin
          reg_write(svn_pkg::CFG_OUT_MODE, 16'd1);
          reg_write(svn_pkg::CFG_MIX_SELECT, 16'd0);
        end
        3: reg_write(svn_pkg::CFG_MIX_SELECT, 16'd2);
        4: reg_write(svn_pkg::CFG_MIX_SELECT, 16'd3);
        default: begin
          reg_write(svn_pkg::CFG_MEAN_TARGET, 16'($urandom_range(0, 255)));
          reg_write(svn_pkg::CFG_VAR_TARGET, 16'($urandom_range(0, 65535)));
          reg_write(svn_pkg::CFG_OUT_MODE, 16'($urandom_range(0, 3) == 0));
          reg_write(svn_pkg::CFG_MIX_SELECT, 16'($urandom_range(0, 3)));
        end
      endcase
      calm = (ph == 9);
      group[0] = $urandom_range(1, SECTORS);
      group[1] = SECTORS - 1;
      group[2] = SECTORS;
      group[3] = $urandom_range(1, SECTORS);
      for (int n = 0; n < 45; n++) begin
        sec = 7'(group[$urandom_range(0, 3)]);
        pick = $urandom_range(0, 99);
        if (pick < 55)      issue(svn_pkg::FUNC_ACCUM, pick_pixel(), sec);
        else if (pick < 82) issue(svn_pkg::FUNC_NORM, pick_pixel(), sec);
        else if (pick < 88) issue(svn_pkg::FUNC_CLEAR, pick_pixel(), sec);
        else issue(2'($urandom_range(0, 3)), 16'($urandom_range(0, 65535)),
                   7'($urandom_range(0, 127)));
        sent++;
      end
    end

    drain();
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/svn_pkg.sv
src/svn_front.sv
src/svn_div.sv
src/svn_sqrt.sv
src/svn_back.sv
src/sector_variance_normalizer_core.sv
tb/sv/svn_result_checker.sv
tb/sv/tb_sector_variance_normalizer_core.sv
